FILE: rtl/rfdd_pkg.sv
package rfdd_pkg;

    localparam int MAX_FORMAT_LEN = 4096;
    localparam int POS_W          = $clog2(MAX_FORMAT_LEN + 1);
    localparam int ACC_W          = 32;
    localparam int BYTE_W         = 8;
    localparam int ALIGN_ADD      = 7;

    typedef enum logic [BYTE_W-1:0] {
        CODE_END      = 8'd0,
        CODE_REPORT_A = 8'd1,
        CODE_REPORT_B = 8'd2,
        CODE_HEADER   = 8'd3,
        CODE_ALIGN    = 8'd4
    } t_code;

    typedef struct packed {
        logic [BYTE_W-1:0] format_byte;
        logic              last;
    } t_item;

    typedef struct packed {
        logic [ACC_W-1:0] size_total;
        logic [ACC_W-1:0] offset_total;
        logic [ACC_W-1:0] header_total;
        logic [POS_W-1:0] header_start;
        logic             header_found;
        logic             missing_width;
    } t_result;

endpackage

FILE: rtl/rfdd_in_if.sv
interface rfdd_in_if;
    logic                             valid;
    logic                             ready;
    logic [rfdd_pkg::BYTE_W-1:0]      format_byte;
    logic                             last;

    modport source (output valid, output format_byte, output last, input ready);
    modport sink   (input valid, input format_byte, input last, output ready);
endinterface

FILE: rtl/rfdd_out_if.sv
interface rfdd_out_if;
    logic                        valid;
    logic                        ready;
    logic [rfdd_pkg::ACC_W-1:0]  size_total;
    logic [rfdd_pkg::ACC_W-1:0]  offset_total;
    logic [rfdd_pkg::ACC_W-1:0]  header_total;
    logic [rfdd_pkg::POS_W-1:0]  header_start;
    logic                        header_found;
    logic                        missing_width;

    modport source (
        output valid, output size_total, output offset_total, output header_total,
        output header_start, output header_found, output missing_width,
        input ready
    );
    modport sink (
        input valid, input size_total, input offset_total, input header_total,
        input header_start, input header_found, input missing_width,
        output ready
    );
endinterface

FILE: rtl/report_format_descriptor_decoder_top.sv
// A byte marked last waits in the input register until the result register is free;
// its totals are then loaded into the result register and shown there.
// Throughput: one byte per cycle unless a last byte waits on a held result; set by the
// combinational update of the flags and 32-bit sums between the input and result registers.
// A held result stalls the next last byte in the input register and the input behind it.
// Reset (i_rst_n, synchronous, active low) clears the core's sums and flags and all valid bits.
module report_format_descriptor_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rfdd_in_if.sink     i_in,
    rfdd_out_if.source  o_out
);
    logic              w_item_valid;
    rfdd_pkg::t_item   w_item;
    logic              w_fire;
    logic              w_out_free;
    rfdd_pkg::t_result w_result;

    rfdd_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_out_free   (w_out_free),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .o_fire       (w_fire)
    );

    rfdd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_item),
        .o_result (w_result)
    );

    rfdd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire && w_item.last),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_out    (o_out)
    );

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_item_valid |-> i_in.ready)
        else $error("input stalled with empty input register");

    a_last_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_item.last |=> o_out.valid)
        else $error("last item produced no result");

    a_offset_needs_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.header_found |-> o_out.header_start == '0)
        else $error("header start set without header");

    a_offset_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.header_start <= rfdd_pkg::POS_W'(rfdd_pkg::MAX_FORMAT_LEN))
        else $error("header start beyond descriptor limit");
endmodule

FILE: rtl/rfdd_in_reg.sv
module rfdd_in_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rfdd_in_if.sink               i_in,
    input  logic                  i_out_free,
    output logic                  o_item_valid,
    output rfdd_pkg::t_item       o_item,
    output logic                  o_fire
);
    logic            r_valid;
    rfdd_pkg::t_item r_item;

    // a last item moves on only when the result register can take it
    assign o_fire       = r_valid && (!r_item.last || i_out_free);
    assign i_in.ready   = !r_valid || o_fire;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.format_byte <= i_in.format_byte;
            r_item.last        <= i_in.last;
        end
    end
endmodule

FILE: rtl/rfdd_core.sv
module rfdd_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  rfdd_pkg::t_item       i_item,
    output rfdd_pkg::t_result     o_result
);
    logic                         r_report;
    logic                         r_header;
    logic                         r_pending;
    logic [rfdd_pkg::POS_W-1:0]   r_pos;
    logic [rfdd_pkg::POS_W-1:0]   r_hdr_pos;
    logic [rfdd_pkg::ACC_W-1:0]   r_off;
    logic [rfdd_pkg::ACC_W-1:0]   r_base;
    logic [rfdd_pkg::ACC_W-1:0]   r_hdr;
    logic [rfdd_pkg::ACC_W-1:0]   r_size;

    logic                         n_report;
    logic                         n_header;
    logic                         n_pending;
    logic                         n_missing;
    logic [rfdd_pkg::POS_W-1:0]   n_pos;
    logic [rfdd_pkg::POS_W-1:0]   n_hdr_pos;
    logic [rfdd_pkg::ACC_W-1:0]   n_off;
    logic [rfdd_pkg::ACC_W-1:0]   n_base;
    logic [rfdd_pkg::ACC_W-1:0]   n_hdr;
    logic [rfdd_pkg::ACC_W-1:0]   n_size;
    logic [rfdd_pkg::ACC_W-1:0]   w_width;
    logic                         w_pos_max;

    localparam logic [rfdd_pkg::ACC_W-1:0] AlignAdd = rfdd_pkg::ACC_W'(rfdd_pkg::ALIGN_ADD);
    localparam logic [rfdd_pkg::POS_W-1:0] PosMax   =
        rfdd_pkg::POS_W'(rfdd_pkg::MAX_FORMAT_LEN);

    assign w_width   = rfdd_pkg::ACC_W'(i_item.format_byte);
    assign w_pos_max = (r_pos == PosMax);

    always_comb begin
        n_report  = r_report;
        n_header  = r_header;
        n_pending = 1'b0;
        n_missing = 1'b0;
        n_hdr_pos = r_hdr_pos;
        n_off     = r_off;
        n_base    = r_base;
        n_hdr     = r_hdr;
        n_size    = r_size;
        n_pos     = w_pos_max ? r_pos : r_pos + 1'b1;

        if (r_pending) begin
            if (r_header) begin
                n_hdr = r_hdr + w_width;
                if (r_report) begin
                    n_off = r_off + w_width;
                end
            end else if (r_report) begin
                n_off = r_off + w_width;
            end else begin
                n_size = r_size + w_width;
            end
        end else begin
            case (i_item.format_byte)
                rfdd_pkg::CODE_END: begin
                    n_report = 1'b0;
                    n_header = 1'b0;
                end
                rfdd_pkg::CODE_REPORT_A,
                rfdd_pkg::CODE_REPORT_B: begin
                    n_report = 1'b1;
                end
                rfdd_pkg::CODE_HEADER: begin
                    n_report  = 1'b0;
                    n_header  = 1'b1;
                    n_hdr_pos = w_pos_max ? PosMax : r_pos + 1'b1;
                end
                rfdd_pkg::CODE_ALIGN: begin
                    if (r_report) begin
                        n_base = r_base + AlignAdd;
                        n_off  = r_base + AlignAdd;
                    end else begin
                        n_base = r_off;
                    end
                    if (r_header) begin
                        n_hdr = (r_hdr + AlignAdd) & ~AlignAdd;
                    end
                end
                default: begin
                    // width byte follows; on the last byte it never comes
                    n_pending = !i_item.last;
                    n_missing = i_item.last;
                end
            endcase
        end
    end

    // header position is never zero once a header start was seen
    always_comb begin
        o_result.size_total    = n_size;
        o_result.offset_total  = n_off;
        o_result.header_total  = n_hdr;
        o_result.header_start  = n_hdr_pos;
        o_result.header_found  = (n_hdr_pos != '0);
        o_result.missing_width = n_missing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last)) begin
            r_report  <= 1'b0;
            r_header  <= 1'b0;
            r_pending <= 1'b0;
            r_pos     <= '0;
            r_hdr_pos <= '0;
            r_off     <= '0;
            r_base    <= '0;
            r_hdr     <= '0;
            r_size    <= '0;
        end else if (i_fire) begin
            r_report  <= n_report;
            r_header  <= n_header;
            r_pending <= n_pending;
            r_pos     <= n_pos;
            r_hdr_pos <= n_hdr_pos;
            r_off     <= n_off;
            r_base    <= n_base;
            r_hdr     <= n_hdr;
            r_size    <= n_size;
        end
    end
endmodule

FILE: rtl/rfdd_out_reg.sv
module rfdd_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  rfdd_pkg::t_result     i_result,
    output logic                  o_free,
    rfdd_out_if.source            o_out
);
    logic              r_valid;
    rfdd_pkg::t_result r_res;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.size_total    = r_res.size_total;
    assign o_out.offset_total  = r_res.offset_total;
    assign o_out.header_total  = r_res.header_total;
    assign o_out.header_start  = r_res.header_start;
    assign o_out.header_found  = r_res.header_found;
    assign o_out.missing_width = r_res.missing_width;
endmodule

FILE: test/descriptor_totals_checker.sv
module descriptor_totals_checker
    import rfdd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rfdd_in_if   i_in,
    rfdd_out_if  i_res,
    output int   o_errors,
    output int   o_outstanding
);

    t_result          totals_q[$];

    logic             report_on;
    logic             header_on;
    logic             width_due;
    logic             header_seen;
    int unsigned      byte_pos;
    int unsigned      header_pos;
    logic [ACC_W-1:0] bit_offset;
    logic [ACC_W-1:0] align_base;
    logic [ACC_W-1:0] header_sum;
    logic [ACC_W-1:0] field_size;

    initial begin
        o_errors      = 0;
        o_outstanding = 0;
    end

    task automatic clear_sums();
        report_on   = 1'b0;
        header_on   = 1'b0;
        width_due   = 1'b0;
        header_seen = 1'b0;
        byte_pos    = 0;
        header_pos  = 0;
        bit_offset  = '0;
        align_base  = '0;
        header_sum  = '0;
        field_size  = '0;
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic lst);
        logic    missing;
        t_result res;
        missing = 1'b0;
        if (width_due) begin
            width_due = 1'b0;
            if (header_on) begin
                header_sum += b;
                if (report_on)
                    bit_offset += b;
            end else if (report_on) begin
                bit_offset += b;
            end else begin
                field_size += b;
            end
        end else begin
            case (b)
                CODE_END: begin
                    report_on = 1'b0;
                    header_on = 1'b0;
                end
                CODE_REPORT_A, CODE_REPORT_B: begin
                    report_on = 1'b1;
                end
                CODE_HEADER: begin
                    report_on   = 1'b0;
                    header_on   = 1'b1;
                    header_seen = 1'b1;
                    header_pos  = (byte_pos + 1 > MAX_FORMAT_LEN) ? MAX_FORMAT_LEN
                                                                  : byte_pos + 1;
                end
                CODE_ALIGN: begin
                    if (report_on) begin
                        align_base += ALIGN_ADD;
                        bit_offset  = align_base;
                    end else begin
                        align_base  = bit_offset;
                    end
                    if (header_on)
                        header_sum = (header_sum + ALIGN_ADD) & ~ACC_W'(ALIGN_ADD);
                end
                default: begin
                    width_due = 1'b1;
                end
            endcase
            // a width code on the closing byte never gets its width
            if (width_due && lst) begin
                width_due = 1'b0;
                missing   = 1'b1;
            end
        end
        if (byte_pos < MAX_FORMAT_LEN)
            byte_pos++;
        if (lst) begin
            res.size_total    = field_size;
            res.offset_total  = bit_offset;
            res.header_total  = header_sum;
            res.header_start  = header_seen ? POS_W'(header_pos) : '0;
            res.header_found  = header_seen;
            res.missing_width = missing;
            totals_q.push_back(res);
            clear_sums();
        end
    endtask

    task automatic check_field(input string name, input logic [ACC_W-1:0] want,
                               input logic [ACC_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_sums();
            totals_q.delete();
        end else begin
            if (i_in.valid && i_in.ready)
                decode_byte(i_in.format_byte, i_in.last);
            if (i_res.valid && i_res.ready) begin
                if (totals_q.size() == 0) begin
                    $error("totals item arrived with none expected");
                    o_errors++;
                end else begin
                    want = totals_q.pop_front();
                    check_field("size_total", want.size_total, i_res.size_total);
                    check_field("offset_total", want.offset_total, i_res.offset_total);
                    check_field("header_total", want.header_total, i_res.header_total);
                    check_field("header_start", want.header_start, i_res.header_start);
                    check_field("header_found", want.header_found, i_res.header_found);
                    check_field("missing_width", want.missing_width, i_res.missing_width);
                end
            end
        end
        o_outstanding <= totals_q.size();
    end

endmodule

FILE: test/tb.sv
module tb;
    import rfdd_pkg::*;

    typedef logic [BYTE_W-1:0] t_bytes[$];

    localparam int                BYTE_MAX      = (1 << BYTE_W) - 1;
    localparam logic [BYTE_W-1:0] WIDTH_CODE_LO = BYTE_W'(CODE_ALIGN + 1);
    localparam logic [BYTE_W-1:0] WIDTH_CODE_HI = '1;
    localparam int                RANDOM_ITEMS  = 375;
    localparam int                QUIET_ITEMS   = 60;
    localparam int                HOLD_CYCLES   = 100;

    logic i_clk;
    logic i_rst_n;
    logic tx_gaps;
    logic rx_gaps;
    logic rx_hold_req;
    int   errors;
    int   outstanding;
    int   sent;

    rfdd_in_if  desc_ch();
    rfdd_out_if totals_ch();

    report_format_descriptor_decoder_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (desc_ch),
        .o_out   (totals_ch)
    );

    descriptor_totals_checker totals_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (desc_ch),
        .i_res         (totals_ch),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #600000;
        $display("FAIL report_format_descriptor_decoder_top");
        $finish;
    end

    // result side: random backpressure, one long hold-off on request
    initial begin
        logic held;
        held = 1'b0;
        totals_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_req && !held) begin
                held = 1'b1;
                totals_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!rx_gaps || $urandom_range(0, 3) != 0) begin
                totals_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                totals_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
    end

    task automatic send_descriptor(input t_bytes d);
        foreach (d[k]) begin
            if (tx_gaps && $urandom_range(0, 5) == 0) begin
                desc_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            desc_ch.valid       <= 1'b1;
            desc_ch.format_byte <= d[k];
            desc_ch.last        <= (k == d.size() - 1);
            @(posedge i_clk);
            while (!desc_ch.ready) @(posedge i_clk);
        end
        sent += d.size();
    endtask

    // well-formed entity stream: width codes always carry their width byte
    function automatic t_bytes make_entities(input int unsigned min_len);
        t_bytes      d;
        int unsigned pick;
        while (d.size() < min_len) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                d.push_back(CODE_END);
            end else if (pick < 4) begin
                d.push_back(pick[0] ? CODE_REPORT_A : CODE_REPORT_B);
            end else if (pick < 7) begin
                d.push_back(CODE_HEADER);
            end else if (pick < 10) begin
                d.push_back(CODE_ALIGN);
            end else begin
                d.push_back(BYTE_W'($urandom_range(WIDTH_CODE_LO, BYTE_MAX)));
                d.push_back(BYTE_W'($urandom_range(0, BYTE_MAX)));
            end
        end
        return d;
    endfunction

    task automatic wait_for_totals();
        int unsigned spins;
        spins = 0;
        desc_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0 && spins < 5000) begin
            @(posedge i_clk);
            spins++;
        end
    endtask

    initial begin
        t_bytes      desc;
        int unsigned kind;
        int          base;
        i_rst_n             <= 1'b0;
        desc_ch.valid       <= 1'b0;
        desc_ch.format_byte <= '0;
        desc_ch.last        <= 1'b0;
        rx_gaps             <= 1'b1;
        rx_hold_req         <= 1'b0;
        tx_gaps = 1'b1;
        sent    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        desc = '{CODE_END};
        send_descriptor(desc);
        // report path, widest width (255), alignment with report flag set
        desc = '{CODE_REPORT_A, WIDTH_CODE_LO, 8'd255, CODE_ALIGN,
                 WIDTH_CODE_HI, 8'd1, CODE_ALIGN};
        send_descriptor(desc);
        // header alone, header plus report, then back to plain size
        desc = '{CODE_HEADER, WIDTH_CODE_HI, 8'd13, CODE_ALIGN, CODE_REPORT_B,
                 WIDTH_CODE_LO, 8'd200, CODE_ALIGN, CODE_END, WIDTH_CODE_HI, 8'd0,
                 CODE_ALIGN};
        send_descriptor(desc);
        // width code on the closing byte
        desc = '{CODE_REPORT_B, WIDTH_CODE_HI};
        send_descriptor(desc);
        desc = '{WIDTH_CODE_LO};
        send_descriptor(desc);
        desc = '{CODE_ALIGN, CODE_HEADER};
        send_descriptor(desc);

        // results back up while descriptors keep coming
        rx_hold_req <= 1'b1;
        tx_gaps = 1'b0;
        repeat (16) begin
            desc = make_entities($urandom_range(1, 3));
            send_descriptor(desc);
        end
        tx_gaps = 1'b1;
        wait_for_totals();

        base = sent;
        while (sent - base < RANDOM_ITEMS) begin
            if (sent - base >= RANDOM_ITEMS - QUIET_ITEMS) begin
                tx_gaps = 1'b0;
                rx_gaps <= 1'b0;
            end
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                desc.delete();
                repeat ($urandom_range(1, 8))
                    desc.push_back(BYTE_W'($urandom_range(0, BYTE_MAX)));
            end else begin
                desc = make_entities($urandom_range(1, 14));
                if (kind == 1)
                    desc.push_back(BYTE_W'($urandom_range(WIDTH_CODE_LO, BYTE_MAX)));
            end
            send_descriptor(desc);
        end

        wait_for_totals();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && outstanding == 0)
            $display("PASS report_format_descriptor_decoder_top");
        else
            $display("FAIL report_format_descriptor_decoder_top");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rfdd_pkg.sv
rtl/rfdd_in_if.sv
rtl/rfdd_out_if.sv
rtl/rfdd_in_reg.sv
rtl/rfdd_core.sv
rtl/rfdd_out_reg.sv
rtl/report_format_descriptor_decoder_top.sv
test/descriptor_totals_checker.sv
test/tb.sv
